// ----- rtl/core/bdq_pkg.sv -----
package bdq_pkg;

    localparam int CAPACITY   = 128;
    localparam int DATA_WIDTH = 32;

    // Wide enough to hold every count from zero to CAPACITY.
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // The read mux is an OR over all cells, split into registered groups.
    localparam int GROUP_SIZE = 16;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef enum logic [3:0] {
        OP_PUSH_BACK   = 4'd0,
        OP_POP_BACK    = 4'd1,
        OP_PUSH_FRONT  = 4'd2,
        OP_POP_FRONT   = 4'd3,
        OP_PUSH_MIDDLE = 4'd4,
        OP_POP_MIDDLE  = 4'd5,
        OP_RESIZE      = 4'd6,
        OP_CLEAR       = 4'd7,
        OP_READ        = 4'd8,
        OP_FRONT       = 4'd9,
        OP_BACK        = 4'd10
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_INSERT,
        ACT_REMOVE,
        ACT_FILL
    } cell_act_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_GATHER,
        PH_MERGE
    } phase_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        cell_act_t              act;
        logic [CNT_W-1:0]       pos;
        logic [CNT_W-1:0]       fill_hi;
        logic [DATA_WIDTH-1:0]  value;
    } cell_ctrl_t;

    // Read selection broadcast to every cell.
    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] idx;
    } rd_sel_t;

endpackage

// ----- rtl/core/bounded_deque_with_middle_ops_core.sv -----
// Bounded deque of up to CAPACITY words held in a chain of cells.
// Input channel (in_valid/in_ready): opcode, value and position of one operation.
// Output channel (out_valid/out_ready): read_data, count, is_empty and status,
// exactly one result transaction for every input transaction, in order.
// An accepted operation updates the whole chain at its accepting edge: every
// cell shifts from its left or right neighbor, loads, zero-fills or holds.
// Reads do not change the chain; the selected cell is found by an OR over all
// cells, registered in groups of GROUP_SIZE and merged into the output register.
// A new operation is taken only after the previous one has passed the
// two-stage read merge; the input is taken again once the previous result is
// in the output register, even if that result is still waiting.
// When the receiver stalls, the finished result waits in the output register
// and a following operation is held in its merge stage until the register
// frees up; no result is dropped.
// Reset clears the element count and the pipeline; the cell contents are not
// cleared, since only cells below the count are ever read.
module bounded_deque_with_middle_ops_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  opcode,
    input  logic [31:0] value,
    input  logic [7:0]  position,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic [7:0]  count,
    output logic        is_empty,
    output logic [1:0]  status
);
    import bdq_pkg::*;

    phase_t state_reg;
    phase_t state_next;

    logic             accept;
    logic             load_out;

    logic [CNT_W-1:0] count_reg;
    cell_ctrl_t       ctrl;
    rd_sel_t          rd_sel_dec;
    rd_sel_t          rd_sel_reg;
    logic [CNT_W-1:0] dec_count;
    status_t          dec_status;

    logic [CNT_W-1:0] res_count_reg;
    status_t          res_status_reg;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];
    logic [DATA_WIDTH-1:0] grp_next  [NUM_GROUPS];
    logic [DATA_WIDTH-1:0] grp_reg   [NUM_GROUPS];
    logic [DATA_WIDTH-1:0] merged;

    logic             out_valid_reg;
    logic [31:0]      read_data_reg;
    logic [CNT_W-1:0] count_out_reg;
    status_t          status_out_reg;

    assign accept = in_valid && in_ready;

    bdq_decode u_decode (
        .en         (accept),
        .opcode     (opcode),
        .value      (value),
        .position   (position),
        .cur_count  (count_reg),
        .ctrl       (ctrl),
        .rd_sel     (rd_sel_dec),
        .next_count (dec_count),
        .status     (dec_status)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_right
            assign right_d = cell_data[i+1];
        end

        bdq_cell u_cell (
            .clk        (clk),
            .cell_idx   (CNT_W'(i)),
            .ctrl       (ctrl),
            .rd_sel     (rd_sel_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rd_tap     (cell_tap[i])
        );
    end

    // First level of the read OR: one partial result per group of cells.
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (g * GROUP_SIZE + k < CAPACITY)
                begin
                    grp_next[g] = grp_next[g] | cell_tap[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_comb
    begin
        merged = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            merged = merged | grp_reg[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        in_ready   = 1'b0;
        unique case (state_reg)
            PH_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = PH_GATHER;
                end
            end
            PH_GATHER:
            begin
                state_next = PH_MERGE;
            end
            PH_MERGE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = PH_IDLE;
                end
            end
            default:
            begin
                state_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            rd_sel_reg.en     <= 1'b0;
            rd_sel_reg.idx    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg  <= dec_count;
                rd_sel_reg <= rd_sel_dec;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_count_reg  <= dec_count;
            res_status_reg <= dec_status;
        end
        if (state_reg == PH_GATHER)
        begin
            grp_reg <= grp_next;
        end
        if (load_out)
        begin
            read_data_reg  <= 32'(merged);
            count_out_reg  <= res_count_reg;
            status_out_reg <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign count     = 8'(count_out_reg);
    assign is_empty  = (count_out_reg == '0);
    assign status    = status_out_reg;

endmodule

// ----- rtl/core/bdq_cell.sv -----
module bdq_cell (
    input  logic                           clk,
    input  logic [bdq_pkg::CNT_W-1:0]      cell_idx,
    input  bdq_pkg::cell_ctrl_t            ctrl,
    input  bdq_pkg::rd_sel_t               rd_sel,
    input  logic [bdq_pkg::DATA_WIDTH-1:0] left_data,
    input  logic [bdq_pkg::DATA_WIDTH-1:0] right_data,
    output logic [bdq_pkg::DATA_WIDTH-1:0] data,
    output logic [bdq_pkg::DATA_WIDTH-1:0] rd_tap
);
    import bdq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.act)
            ACT_HOLD:
            begin
                data_next = data_reg;
            end
            ACT_INSERT:
            begin
                if (cell_idx > ctrl.pos)
                begin
                    data_next = left_data;
                end
                else if (cell_idx == ctrl.pos)
                begin
                    data_next = ctrl.value;
                end
            end
            ACT_REMOVE:
            begin
                if (cell_idx >= ctrl.pos)
                begin
                    data_next = right_data;
                end
            end
            ACT_FILL:
            begin
                if (cell_idx >= ctrl.pos && cell_idx < ctrl.fill_hi)
                begin
                    data_next = '0;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data   = data_reg;
    assign rd_tap = (rd_sel.en && rd_sel.idx == cell_idx) ? data_reg : '0;

endmodule

// ----- rtl/core/bdq_decode.sv -----
module bdq_decode (
    input  logic                          en,
    input  logic [3:0]                    opcode,
    input  logic [31:0]                   value,
    input  logic [7:0]                    position,
    input  logic [bdq_pkg::CNT_W-1:0]     cur_count,
    output bdq_pkg::cell_ctrl_t           ctrl,
    output bdq_pkg::rd_sel_t              rd_sel,
    output logic [bdq_pkg::CNT_W-1:0]     next_count,
    output bdq_pkg::status_t              status
);
    import bdq_pkg::*;

    logic             full;
    logic             empty;
    logic [CNT_W:0]   cnt_inc;
    logic [CNT_W-1:0] cnt_dec;
    logic [CNT_W-1:0] pos_cnt;
    logic             pos_over;

    assign full     = (int'(cur_count) >= CAPACITY);
    assign empty    = (cur_count == '0);
    assign cnt_inc  = {1'b0, cur_count} + (CNT_W + 1)'(1);
    assign cnt_dec  = cur_count - CNT_W'(1);
    assign pos_over = (int'(position) > CAPACITY);
    assign pos_cnt  = CNT_W'(position);

    always_comb
    begin
        ctrl.act     = ACT_HOLD;
        ctrl.pos     = '0;
        ctrl.fill_hi = '0;
        ctrl.value   = DATA_WIDTH'(value);
        rd_sel.en    = 1'b0;
        rd_sel.idx   = '0;
        next_count   = cur_count;
        status       = ST_OK;

        unique case (opcode)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_PUSH_MIDDLE:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctrl.act   = ACT_INSERT;
                    next_count = CNT_W'(cnt_inc);
                    if (opcode == OP_PUSH_BACK)
                    begin
                        ctrl.pos = cur_count;
                    end
                    else if (opcode == OP_PUSH_MIDDLE)
                    begin
                        ctrl.pos = CNT_W'(cnt_inc >> 1);
                    end
                end
            end
            OP_POP_BACK, OP_POP_FRONT, OP_POP_MIDDLE:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    ctrl.act   = ACT_REMOVE;
                    next_count = cnt_dec;
                    if (opcode == OP_POP_BACK)
                    begin
                        ctrl.pos = cnt_dec;
                    end
                    else if (opcode == OP_POP_MIDDLE)
                    begin
                        ctrl.pos = cur_count >> 1;
                    end
                end
            end
            OP_RESIZE:
            begin
                if (pos_over)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    ctrl.act     = ACT_FILL;
                    ctrl.pos     = cur_count;
                    ctrl.fill_hi = pos_cnt;
                    next_count   = pos_cnt;
                end
            end
            OP_CLEAR:
            begin
                next_count = '0;
            end
            OP_READ, OP_FRONT, OP_BACK:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (opcode == OP_FRONT)
                begin
                    rd_sel.en = 1'b1;
                end
                else if (opcode == OP_BACK)
                begin
                    rd_sel.en  = 1'b1;
                    rd_sel.idx = cnt_dec;
                end
                else if (int'(position) >= int'(cur_count))
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    rd_sel.en  = 1'b1;
                    rd_sel.idx = pos_cnt;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase

        // Nothing moves in the chain unless a transaction is accepted.
        if (!en)
        begin
            ctrl.act = ACT_HOLD;
        end
    end

endmodule

// ----- tb/bounded_deque_with_middle_ops_core_tb.sv -----
`timescale 1ns / 1ps

module bounded_deque_with_middle_ops_core_tb;

    import bdq_pkg::*;

    // Opcodes above the last defined operation are accepted and do nothing.
    localparam logic [3:0] OP_UNUSED_FIRST = 4'd11;
    localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

    localparam int NUM_DIRECTED = 27;
    localparam int NUM_SEGMENTS = 16;
    localparam int SEG_ITEMS    = 95;
    localparam int HOLD_SEGMENT  = 2;
    localparam int DRAIN_SEGMENT = 8;
    localparam int QUIET_FROM    = 14;

    typedef struct packed {
        logic [31:0] rd;
        logic [7:0]  cnt;
        logic        empty;
        status_t     st;
    } deque_result_t;

    typedef struct packed {
        logic [3:0]    op;
        logic [31:0]   word;
        logic [7:0]    pos;
        logic          typed;
        deque_result_t want;
    } directed_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [3:0]  opcode    = '0;
    logic [31:0] value     = '0;
    logic [7:0]  position  = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [31:0] read_data;
    logic [7:0]  count;
    logic        is_empty;
    logic [1:0]  status;

    // Shadow copy of the deque contents and length.
    logic [31:0] deque_mem [CAPACITY];
    int          deque_len;

    deque_result_t pending_results [$];

    int mismatches    = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int peak_len      = 0;
    int status_hits [4] = '{0, 0, 0, 0};

    int gap_pct       = 0;
    int rx_stall_pct  = 0;
    int hold_cycles   = 0;
    bit quiet_tail    = 1'b0;

    int push_pct_tab  [NUM_SEGMENTS] = '{85, 95, 95, 10, 50, 90, 5, 60,
                                         95, 30, 50, 97, 3, 70, 40, 50};
    int gap_pct_tab   [NUM_SEGMENTS] = '{20, 0, 0, 40, 15, 0, 30, 60,
                                         20, 0, 40, 15, 25, 0, 0, 0};
    int stall_pct_tab [NUM_SEGMENTS] = '{30, 0, 0, 60, 15, 40, 0, 30,
                                         50, 20, 0, 60, 30, 10, 0, 0};

    directed_row_t dir_tab [NUM_DIRECTED] = '{
        '{OP_POP_BACK,     32'h0,        8'd0,   1'b1, '{32'h0, 8'd0, 1'b1, ST_EMPTY}},
        '{OP_POP_FRONT,    32'h0,        8'd0,   1'b1, '{32'h0, 8'd0, 1'b1, ST_EMPTY}},
        '{OP_POP_MIDDLE,   32'h0,        8'd0,   1'b1, '{32'h0, 8'd0, 1'b1, ST_EMPTY}},
        '{OP_FRONT,        32'h0,        8'd0,   1'b1, '{32'h0, 8'd0, 1'b1, ST_EMPTY}},
        '{OP_BACK,         32'h0,        8'd0,   1'b1, '{32'h0, 8'd0, 1'b1, ST_EMPTY}},
        '{OP_READ,         32'h0,        8'd0,   1'b1, '{32'h0, 8'd0, 1'b1, ST_EMPTY}},
        '{OP_PUSH_BACK,    32'hFFFFFFFF, 8'd0,   1'b1, '{32'h0, 8'd1, 1'b0, ST_OK}},
        '{OP_PUSH_FRONT,   32'h0,        8'd0,   1'b1, '{32'h0, 8'd2, 1'b0, ST_OK}},
        '{OP_PUSH_MIDDLE,  32'hA5A5A5A5, 8'd0,   1'b0, '0},
        '{OP_READ,         32'h0,        8'd1,   1'b0, '0},
        '{OP_READ,         32'h0,        8'd255, 1'b1, '{32'h0, 8'd3, 1'b0, ST_RANGE}},
        '{OP_FRONT,        32'h0,        8'd0,   1'b0, '0},
        '{OP_BACK,         32'h0,        8'd0,   1'b0, '0},
        '{OP_POP_MIDDLE,   32'h0,        8'd0,   1'b0, '0},
        '{OP_UNUSED_FIRST, 32'h12345678, 8'd7,   1'b0, '0},
        '{OP_UNUSED_LAST,  32'hFFFFFFFF, 8'd255, 1'b0, '0},
        '{OP_RESIZE,       32'h0,        8'd255, 1'b1, '{32'h0, 8'd2, 1'b0, ST_RANGE}},
        '{OP_RESIZE,       32'h0,        8'(CAPACITY + 1), 1'b1,
          '{32'h0, 8'd2, 1'b0, ST_RANGE}},
        '{OP_RESIZE,       32'h0,        8'(CAPACITY), 1'b1,
          '{32'h0, 8'(CAPACITY), 1'b0, ST_OK}},
        '{OP_PUSH_BACK,    32'h1,        8'd0,   1'b1, '{32'h0, 8'(CAPACITY), 1'b0, ST_FULL}},
        '{OP_PUSH_FRONT,   32'h2,        8'd0,   1'b1, '{32'h0, 8'(CAPACITY), 1'b0, ST_FULL}},
        '{OP_PUSH_MIDDLE,  32'h3,        8'd0,   1'b1, '{32'h0, 8'(CAPACITY), 1'b0, ST_FULL}},
        '{OP_READ,         32'h0,        8'(CAPACITY - 1), 1'b1,
          '{32'h0, 8'(CAPACITY), 1'b0, ST_OK}},
        '{OP_READ,         32'h0,        8'(CAPACITY), 1'b1,
          '{32'h0, 8'(CAPACITY), 1'b0, ST_RANGE}},
        '{OP_POP_FRONT,    32'h0,        8'd0,   1'b0, '0},
        '{OP_CLEAR,        32'h0,        8'd0,   1'b1, '{32'h0, 8'd0, 1'b1, ST_OK}},
        '{OP_RESIZE,       32'h0,        8'd0,   1'b1, '{32'h0, 8'd0, 1'b1, ST_OK}}
    };

    bounded_deque_with_middle_ops_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .value     (value),
        .position  (position),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data),
        .count     (count),
        .is_empty  (is_empty),
        .status    (status)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Applies one operation to the shadow deque and returns the result it should give.
    function automatic deque_result_t apply_deque_op(input logic [3:0] op,
                                                     input logic [31:0] word,
                                                     input logic [7:0] pos);
        deque_result_t res;
        int            idx;
        int            i;
        res    = '0;
        res.st = ST_OK;
        idx    = 0;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_PUSH_MIDDLE:
            begin
                if (deque_len >= CAPACITY)
                    res.st = ST_FULL;
                else
                begin
                    if (op == OP_PUSH_BACK)
                        idx = deque_len;
                    else if (op == OP_PUSH_MIDDLE)
                        idx = (deque_len + 1) / 2;
                    for (i = deque_len; i > idx; i--)
                        deque_mem[i] = deque_mem[i - 1];
                    deque_mem[idx] = word;
                    deque_len++;
                end
            end
            OP_POP_BACK, OP_POP_FRONT, OP_POP_MIDDLE:
            begin
                if (deque_len == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    if (op == OP_POP_BACK)
                        idx = deque_len - 1;
                    else if (op == OP_POP_MIDDLE)
                        idx = deque_len / 2;
                    for (i = idx; i + 1 < deque_len; i++)
                        deque_mem[i] = deque_mem[i + 1];
                    deque_len--;
                end
            end
            OP_RESIZE:
            begin
                if (pos > CAPACITY)
                    res.st = ST_RANGE;
                else
                begin
                    for (i = deque_len; i < pos; i++)
                        deque_mem[i] = '0;
                    deque_len = int'(pos);
                end
            end
            OP_CLEAR:
                deque_len = 0;
            OP_READ, OP_FRONT, OP_BACK:
            begin
                if (deque_len == 0)
                    res.st = ST_EMPTY;
                else if (op == OP_FRONT)
                    res.rd = deque_mem[0];
                else if (op == OP_BACK)
                    res.rd = deque_mem[deque_len - 1];
                else if (pos >= deque_len)
                    res.st = ST_RANGE;
                else
                    res.rd = deque_mem[pos];
            end
            default:
                ;
        endcase
        res.cnt   = 8'(deque_len);
        res.empty = (deque_len == 0);
        status_hits[res.st]++;
        if (deque_len > peak_len)
            peak_len = deque_len;
        return res;
    endfunction

    // Presents one transaction and holds it until the block takes it.
    task automatic offer_op(input logic [3:0] op, input logic [31:0] word,
                            input logic [7:0] pos, input logic typed,
                            input deque_result_t typed_res);
        deque_result_t res;
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= word;
        position <= pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        res = apply_deque_op(op, word, pos);
        pending_results.push_back(typed ? typed_res : res);
        items_sent++;
    endtask

    task automatic sender_gap();
        int n;
        if (!quiet_tail && $urandom_range(99) < gap_pct)
        begin
            n = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    initial
    begin : receiver
        int n;
        forever
        begin
            if (hold_cycles > 0)
            begin
                n           = hold_cycles;
                hold_cycles = 0;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (quiet_tail)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(99) < rx_stall_pct)
            begin
                n = $urandom_range(1, 14);
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                n = $urandom_range(1, 14);
                out_ready <= 1'b1;
                repeat (n) @(posedge clk);
            end
        end
    end

    initial
    begin : result_checker
        deque_result_t got;
        deque_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.rd    = read_data;
                got.cnt   = count;
                got.empty = is_empty;
                got.st    = status_t'(status);
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing pending: rd=%h cnt=%0d empty=%b st=%0d",
                                 $realtime, got.rd, got.cnt, got.empty, got.st);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: result %0d mismatch: expected rd=%h cnt=%0d ",
                                      "empty=%b st=%0d, got rd=%h cnt=%0d empty=%b st=%0d"},
                                     $realtime, results_seen, want.rd, want.cnt, want.empty,
                                     want.st, got.rd, got.cnt, got.empty, got.st);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        int          seg;
        int          k;
        int          r;
        int          push_pct;
        logic [3:0]  op;
        logic [31:0] word;
        logic [7:0]  pos;
        deque_len = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct      = 25;
        rx_stall_pct = 30;
        for (k = 0; k < NUM_DIRECTED; k++)
        begin
            offer_op(dir_tab[k].op, dir_tab[k].word, dir_tab[k].pos,
                     dir_tab[k].typed, dir_tab[k].want);
            sender_gap();
        end

        for (seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            push_pct     = push_pct_tab[seg];
            gap_pct      = gap_pct_tab[seg];
            rx_stall_pct = stall_pct_tab[seg];
            if (seg >= QUIET_FROM)
                quiet_tail = 1'b1;
            if (seg == HOLD_SEGMENT)
            begin
                // The receiver stops for a long stretch while items keep coming,
                // so the output and merge stages fill and the input stalls.
                gap_pct     = 0;
                hold_cycles = 400;
            end
            if (seg == DRAIN_SEGMENT)
            begin
                in_valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            for (k = 0; k < SEG_ITEMS; k++)
            begin
                r    = $urandom_range(99);
                word = $urandom;
                pos  = 8'($urandom_range(0, 255));
                if ($urandom_range(9) == 0)
                    word = '0;
                else if ($urandom_range(9) == 0)
                    word = '1;
                if (r < 3)
                    op = 4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
                else if (r < 6)
                begin
                    op = OP_RESIZE;
                    if ($urandom_range(99) < 80)
                        pos = 8'($urandom_range(0, CAPACITY));
                end
                else if (r < 7)
                    op = OP_CLEAR;
                else if (r < 30)
                begin
                    case ($urandom_range(2))
                        0:       op = OP_READ;
                        1:       op = OP_FRONT;
                        default: op = OP_BACK;
                    endcase
                    if (deque_len > 0 && $urandom_range(99) < 75)
                        pos = 8'($urandom_range(0, deque_len - 1));
                end
                else if ($urandom_range(99) < push_pct)
                begin
                    case ($urandom_range(2))
                        0:       op = OP_PUSH_BACK;
                        1:       op = OP_PUSH_FRONT;
                        default: op = OP_PUSH_MIDDLE;
                    endcase
                end
                else
                begin
                    case ($urandom_range(2))
                        0:       op = OP_POP_BACK;
                        1:       op = OP_POP_FRONT;
                        default: op = OP_POP_MIDDLE;
                    endcase
                end
                offer_op(op, word, pos, 1'b0, '0);
                sender_gap();
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d operations sent, %0d results checked, peak length %0d",
                 items_sent, results_seen, peak_len);
        $display("status seen: ok %0d, full %0d, empty %0d, out of range %0d",
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
                 status_hits[ST_RANGE]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("timeout with %0d results still pending", pending_results.size());
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/bdq_pkg.sv
rtl/core/bdq_cell.sv
rtl/core/bdq_decode.sv
rtl/core/bounded_deque_with_middle_ops_core.sv
tb/bounded_deque_with_middle_ops_core_tb.sv
